FILE: sv/mmc3bm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MMC3 multicart bank mapper package
// Shared widths, register indexes, address decode constants and state types.
// ----------------------------------------------------------------------------
package mmc3bm_pkg;

   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int PRG_BANK_W  = 6;
   localparam int CHR_BANK_W  = 9;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 9;
   localparam int NUM_REGS    = 8;
   localparam int NUM_PRG     = 4;
   localparam int NUM_CHR     = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PRG_BANK_MASK = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHR_BANK_MASK = 8'd1;

   localparam logic [PRG_BANK_W-1:0] PRG_MASK_RESET = 6'h3F;
   localparam logic [CHR_BANK_W-1:0] CHR_MASK_RESET = 9'h1FF;

   // high-window register decode
   localparam logic [ADDR_W-1:0] REG_ADDR_MASK    = 16'hE001;
   localparam logic [ADDR_W-1:0] BANK_SELECT_ADDR = 16'h8000;
   localparam logic [ADDR_W-1:0] BANK_DATA_ADDR   = 16'h8001;
   localparam logic [2:0]        WRAM_WINDOW      = 3'b011;

   // bank arithmetic constants
   localparam logic [DATA_W-1:0] GNROM_MODE_BITS = 8'h06;
   localparam logic [DATA_W-1:0] GNROM_LOW_MASK  = 8'hFD;
   localparam logic [DATA_W-1:0] GNROM_HIGH_SET  = 8'h02;
   localparam logic [DATA_W-1:0] PRG_FIXED_E     = 8'h0E;
   localparam logic [DATA_W-1:0] PRG_FIXED_F     = 8'h0F;
   localparam logic [DATA_W-1:0] CHR_EVEN_MASK   = 8'hFE;
   localparam logic [DATA_W-1:0] CHR_ODD_SET     = 8'h01;
   localparam logic [DATA_W-1:0] PRG_INVERT_BIT  = 8'h40;
   localparam logic [DATA_W-1:0] CHR_INVERT_BIT  = 8'h80;
   localparam logic [DATA_W-1:0] OUTER_CHR_BIT6  = 8'h08;

   localparam logic [NUM_REGS-1:0][DATA_W-1:0] BANK_REGS_RESET =
      {8'd0, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

   typedef struct packed {
      logic [DATA_W-1:0]                 outer_bank;
      logic [DATA_W-1:0]                 bank_select;
      logic [NUM_REGS-1:0][DATA_W-1:0]   bank_regs;
   } mapper_state_type;

   typedef struct packed {
      logic [NUM_PRG-1:0][PRG_BANK_W-1:0] prg;
      logic [NUM_CHR-1:0][CHR_BANK_W-1:0] chr;
   } bank_map_type;

endpackage

FILE: sv/mmc3bm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MMC3 multicart mapper register file
// Decodes one CPU write and updates outer bank, bank select and bank registers.
// Presents the post-write state combinationally for the bank logic.
// ----------------------------------------------------------------------------
module mmc3bm_regs
   import mmc3bm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  write_en,
   input  logic [ADDR_W-1:0]     address,
   input  logic [DATA_W-1:0]     data,
   input  logic                  ram_write_enabled,
   output mapper_state_type      state_next
);

   mapper_state_type state_ff;
   mapper_state_type state_in;
   logic [ADDR_W-1:0] reg_addr;

   assign reg_addr = address & REG_ADDR_MASK;

   always_comb begin
      state_in = state_ff;
      if (address[15:13] == WRAM_WINDOW) begin
         if (ram_write_enabled) begin
            state_in.outer_bank = data;
         end
      end else if (reg_addr == BANK_SELECT_ADDR) begin
         state_in.bank_select = data;
      end else if (reg_addr == BANK_DATA_ADDR) begin
         state_in.bank_regs[state_ff.bank_select[2:0]] = data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.outer_bank  <= '0;
         state_ff.bank_select <= '0;
         state_ff.bank_regs   <= BANK_REGS_RESET;
      end else if (write_en) begin
         state_ff <= state_in;
      end
   end

   assign state_next = state_in;

endmodule

FILE: sv/mmc3bm_banks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MMC3 multicart bank number logic
// Maps the register state to four 8K PRG and eight 1K CHR bank numbers.
// ----------------------------------------------------------------------------
module mmc3bm_banks
   import mmc3bm_pkg::*;
(
   input  mapper_state_type          state,
   input  logic [PRG_BANK_W-1:0]     prg_bank_mask,
   input  logic [CHR_BANK_W-1:0]     chr_bank_mask,
   output bank_map_type              banks
);

   logic                              gnrom;
   logic                              prg_inv;
   logic                              chr_inv;
   logic [1:0]                        prg_base;
   logic [NUM_PRG-1:0][DATA_W-1:0]    prg_inner;
   logic [NUM_CHR-1:0][DATA_W-1:0]    chr_logical;
   logic [DATA_W-1:0]                 chr_high;
   logic [2:0]                        slot_sel;

   assign gnrom    = (state.outer_bank & GNROM_MODE_BITS) == GNROM_MODE_BITS;
   assign prg_inv  = |(state.bank_select & PRG_INVERT_BIT);
   assign chr_inv  = |(state.bank_select & CHR_INVERT_BIT);
   assign prg_base = state.outer_bank[2:1];

   // outer bits ORed into the CHR low byte: bit 3 -> bit 6, bit 1 -> bit 7
   assign chr_high = {state.outer_bank[1], |(state.outer_bank & OUTER_CHR_BIT6), 6'd0};

   always_comb begin
      if (gnrom) begin
         prg_inner[0] = state.bank_regs[6] & GNROM_LOW_MASK;
         prg_inner[1] = state.bank_regs[7] & GNROM_LOW_MASK;
         prg_inner[2] = state.bank_regs[6] | GNROM_HIGH_SET;
         prg_inner[3] = state.bank_regs[7] | GNROM_HIGH_SET;
      end else begin
         prg_inner[0] = prg_inv ? PRG_FIXED_E : state.bank_regs[6];
         prg_inner[1] = state.bank_regs[7];
         prg_inner[2] = prg_inv ? state.bank_regs[6] : PRG_FIXED_E;
         prg_inner[3] = PRG_FIXED_F;
      end
   end

   always_comb begin
      chr_logical[0] = state.bank_regs[0] & CHR_EVEN_MASK;
      chr_logical[1] = state.bank_regs[0] | CHR_ODD_SET;
      chr_logical[2] = state.bank_regs[1] & CHR_EVEN_MASK;
      chr_logical[3] = state.bank_regs[1] | CHR_ODD_SET;
      chr_logical[4] = state.bank_regs[2];
      chr_logical[5] = state.bank_regs[3];
      chr_logical[6] = state.bank_regs[4];
      chr_logical[7] = state.bank_regs[5];
   end

   always_comb begin
      slot_sel = '0;
      for (int i = 0; i < NUM_PRG; i++) begin
         banks.prg[i] = {prg_base, prg_inner[i][3:0]} & prg_bank_mask;
      end
      // swap the 2K and 1K halves when CHR inversion is set
      for (int i = 0; i < NUM_CHR; i++) begin
         slot_sel     = 3'(i) ^ {chr_inv, 2'b00};
         banks.chr[i] = {state.outer_bank[0], chr_logical[slot_sel] | chr_high}
                        & chr_bank_mask;
      end
   end

endmodule

FILE: sv/multicart_mmc3_bank_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MMC3 multicart bank mapper
// Tracks CPU writes to an MMC3-style mapper with an outer bank register and
// returns the PRG and CHR bank numbers after every write.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one CPU bus write per transaction (address, data, RAM enable).
//   rsp_*  : one transaction per request carrying the four 8K PRG and eight
//            1K CHR bank numbers selected after that write.
//   csr_*  : mask register writes, index 0 = PRG mask, 1 = CHR mask; other
//            indexes are ignored. csr_ready is always high. Write only while
//            no request is outstanding.
// Timing: the result of a request is registered at the edge that accepts it
//   and is valid in the following cycle. The register update, the
//   bank muxes and the mask all sit in front of the single result register,
//   so one transaction is accepted every cycle while req_ready is high.
// Stalls: req_ready is high while the result register is empty or is being
//   taken in the same cycle; with rsp_ready low a held result blocks new
//   requests and stays unchanged.
// Reset: masks return to all ones, outer bank and bank select to zero and
//   the bank registers to 0,2,4,5,6,7,0,0; no result is pending.
// ----------------------------------------------------------------------------
module multicart_mmc3_bank_mapper
   import mmc3bm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ADDR_W-1:0]       req_address,
   input  logic [DATA_W-1:0]       req_data,
   input  logic                    req_ram_write_enabled,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [PRG_BANK_W-1:0]   rsp_prg_bank_slot0,
   output logic [PRG_BANK_W-1:0]   rsp_prg_bank_slot1,
   output logic [PRG_BANK_W-1:0]   rsp_prg_bank_slot2,
   output logic [PRG_BANK_W-1:0]   rsp_prg_bank_slot3,
   output logic [CHR_BANK_W-1:0]   rsp_chr_bank_slot0,
   output logic [CHR_BANK_W-1:0]   rsp_chr_bank_slot1,
   output logic [CHR_BANK_W-1:0]   rsp_chr_bank_slot2,
   output logic [CHR_BANK_W-1:0]   rsp_chr_bank_slot3,
   output logic [CHR_BANK_W-1:0]   rsp_chr_bank_slot4,
   output logic [CHR_BANK_W-1:0]   rsp_chr_bank_slot5,
   output logic [CHR_BANK_W-1:0]   rsp_chr_bank_slot6,
   output logic [CHR_BANK_W-1:0]   rsp_chr_bank_slot7,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [PRG_BANK_W-1:0] prg_mask_ff;
   logic [CHR_BANK_W-1:0] chr_mask_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   bank_map_type          rsp_banks_ff;
   bank_map_type          banks;
   mapper_state_type      state_next;
   logic                  req_fire;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_mask_ff <= PRG_MASK_RESET;
         chr_mask_ff <= CHR_MASK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PRG_BANK_MASK: prg_mask_ff <= csr_wdata[PRG_BANK_W-1:0];
            CSR_CHR_BANK_MASK: chr_mask_ff <= csr_wdata[CHR_BANK_W-1:0];
            default: ;
         endcase
      end
   end

   mmc3bm_regs u_regs (
      .clock             (clock),
      .reset             (reset),
      .write_en          (req_fire),
      .address           (req_address),
      .data              (req_data),
      .ram_write_enabled (req_ram_write_enabled),
      .state_next        (state_next)
   );

   mmc3bm_banks u_banks (
      .state         (state_next),
      .prg_bank_mask (prg_mask_ff),
      .chr_bank_mask (chr_mask_ff),
      .banks         (banks)
   );

   // hold the result until taken, refill on every accepted transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_banks_ff <= banks;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_prg_bank_slot0 = rsp_banks_ff.prg[0];
   assign rsp_prg_bank_slot1 = rsp_banks_ff.prg[1];
   assign rsp_prg_bank_slot2 = rsp_banks_ff.prg[2];
   assign rsp_prg_bank_slot3 = rsp_banks_ff.prg[3];
   assign rsp_chr_bank_slot0 = rsp_banks_ff.chr[0];
   assign rsp_chr_bank_slot1 = rsp_banks_ff.chr[1];
   assign rsp_chr_bank_slot2 = rsp_banks_ff.chr[2];
   assign rsp_chr_bank_slot3 = rsp_banks_ff.chr[3];
   assign rsp_chr_bank_slot4 = rsp_banks_ff.chr[4];
   assign rsp_chr_bank_slot5 = rsp_banks_ff.chr[5];
   assign rsp_chr_bank_slot6 = rsp_banks_ff.chr[6];
   assign rsp_chr_bank_slot7 = rsp_banks_ff.chr[7];

endmodule

FILE: bench/tb_multicart_mmc3_bank_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the MMC3 multicart bank mapper
// Streams CPU bus writes into the mapper, tracks the mapper registers and the
// bank masks in a local shadow copy, and checks every returned PRG/CHR bank
// map against the map that the shadow predicts. Both sides idle at random,
// the receiver stalls long once, and the masks change between phases.
// ----------------------------------------------------------------------------
module tb_multicart_mmc3_bank_mapper;
   import mmc3bm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_STALL  = 60;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] data;
      logic              ram_en;
   } cpu_write_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ADDR_W-1:0]      req_address = '0;
   logic [DATA_W-1:0]      req_data = '0;
   logic                   req_ram_write_enabled = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PRG_BANK_W-1:0]  rsp_prg_bank_slot0, rsp_prg_bank_slot1;
   logic [PRG_BANK_W-1:0]  rsp_prg_bank_slot2, rsp_prg_bank_slot3;
   logic [CHR_BANK_W-1:0]  rsp_chr_bank_slot0, rsp_chr_bank_slot1;
   logic [CHR_BANK_W-1:0]  rsp_chr_bank_slot2, rsp_chr_bank_slot3;
   logic [CHR_BANK_W-1:0]  rsp_chr_bank_slot4, rsp_chr_bank_slot5;
   logic [CHR_BANK_W-1:0]  rsp_chr_bank_slot6, rsp_chr_bank_slot7;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   cpu_write_type    pending_writes[$];
   bank_map_type     expected_maps[$];
   mapper_state_type shadow_state;
   cpu_write_type    current_write;
   logic [PRG_BANK_W-1:0] prg_mask_shadow = PRG_MASK_RESET;
   logic [CHR_BANK_W-1:0] chr_mask_shadow = CHR_MASK_RESET;
   bit               offering = 1'b0;
   bit               no_idle = 1'b0;
   int               gap_left = 0;
   int               stall_left = 0;
   int               long_stall_asks = 0;
   int               long_stall_seen = 0;
   int               error_count = 0;
   int               cycle_count = 0;

   multicart_mmc3_bank_mapper dut (.*);

   always #5 clock = ~clock;

   // Register update for one CPU write.
   function automatic mapper_state_type apply_cpu_write(mapper_state_type s, cpu_write_type w);
      logic [ADDR_W-1:0] sel;
      sel = w.address & REG_ADDR_MASK;
      if (w.address[15:13] == WRAM_WINDOW) begin
         if (w.ram_en)
            s.outer_bank = w.data;
      end else if (w.address[15]) begin
         if (sel == BANK_SELECT_ADDR)
            s.bank_select = w.data;
         else if (sel == BANK_DATA_ADDR)
            s.bank_regs[s.bank_select[2:0]] = w.data;
      end
      return s;
   endfunction

   // PRG and CHR bank numbers selected by a register state.
   function automatic bank_map_type compute_bank_map(mapper_state_type s,
                                                     logic [PRG_BANK_W-1:0] pm,
                                                     logic [CHR_BANK_W-1:0] cm);
      bank_map_type m;
      logic [DATA_W-1:0] inner;
      logic [DATA_W-1:0] low;
      for (int p = 0; p < NUM_PRG; p++) begin
         if ((s.outer_bank & GNROM_MODE_BITS) == GNROM_MODE_BITS) begin
            inner = s.bank_regs[6 + (p % 2)];
            inner = (p < 2) ? (inner & GNROM_LOW_MASK) : (inner | GNROM_HIGH_SET);
         end else begin
            case (p)
               0: inner = s.bank_select[6] ? PRG_FIXED_E : s.bank_regs[6];
               1: inner = s.bank_regs[7];
               2: inner = s.bank_select[6] ? s.bank_regs[6] : PRG_FIXED_E;
               default: inner = PRG_FIXED_F;
            endcase
         end
         m.prg[p] = {s.outer_bank[2:1], inner[3:0]} & pm;
      end
      for (int c = 0; c < NUM_CHR; c++) begin
         if (c < 4) begin
            low = s.bank_regs[c / 2];
            low = (c % 2) ? (low | CHR_ODD_SET) : (low & CHR_EVEN_MASK);
         end else begin
            low = s.bank_regs[c - 2];
         end
         low[6] = low[6] | s.outer_bank[3];
         low[7] = low[7] | s.outer_bank[1];
         m.chr[c ^ (s.bank_select[7] ? 4 : 0)] = {s.outer_bank[0], low} & cm;
      end
      return m;
   endfunction

   // Driver: offer pending writes, predict on every accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         gap_left = 0;
         shadow_state.outer_bank = '0;
         shadow_state.bank_select = '0;
         shadow_state.bank_regs = BANK_REGS_RESET;
      end else begin
         if (req_valid && req_ready) begin
            shadow_state = apply_cpu_write(shadow_state, current_write);
            expected_maps.push_back(compute_bank_map(shadow_state, prg_mask_shadow,
                                                     chr_mask_shadow));
            gap_left = no_idle ? 0 : $urandom_range(0, 5);
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_writes.size() > 0) begin
               current_write = pending_writes.pop_front();
               req_address <= current_write.address;
               req_data <= current_write.data;
               req_ram_write_enabled <= current_write.ram_en;
               offering = 1'b1;
            end
         end
         req_valid <= offering;
      end
   end

   // Monitor: take results with random back-pressure and check each field.
   always @(posedge clock) begin
      bank_map_type got;
      bank_map_type want;
      logic ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.prg = {rsp_prg_bank_slot3, rsp_prg_bank_slot2,
                       rsp_prg_bank_slot1, rsp_prg_bank_slot0};
            got.chr = {rsp_chr_bank_slot7, rsp_chr_bank_slot6,
                       rsp_chr_bank_slot5, rsp_chr_bank_slot4,
                       rsp_chr_bank_slot3, rsp_chr_bank_slot2,
                       rsp_chr_bank_slot1, rsp_chr_bank_slot0};
            if (expected_maps.size() == 0) begin
               $error("bank map transaction with no write outstanding");
               error_count++;
            end else begin
               want = expected_maps.pop_front();
               for (int i = 0; i < NUM_PRG; i++)
                  if (got.prg[i] !== want.prg[i]) begin
                     $error("prg_bank_slot%0d: expected %0d, actual %0d",
                            i, want.prg[i], got.prg[i]);
                     error_count++;
                  end
               for (int i = 0; i < NUM_CHR; i++)
                  if (got.chr[i] !== want.chr[i]) begin
                     $error("chr_bank_slot%0d: expected %0d, actual %0d",
                            i, want.chr[i], got.chr[i]);
                     error_count++;
                  end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (long_stall_seen != long_stall_asks) begin
            long_stall_seen = long_stall_asks;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_multicart_mmc3_bank_mapper: done, errors");
         $finish;
      end
   end

   function automatic cpu_write_type cpu_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                                               logic en);
      cpu_write_type w;
      w.address = a;
      w.data = d;
      w.ram_en = en;
      return w;
   endfunction

   task automatic write_mask(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PRG_BANK_MASK)
         prg_mask_shadow = val[PRG_BANK_W-1:0];
      else if (idx == CSR_CHR_BANK_MASK)
         chr_mask_shadow = val;
      csr_valid <= 1'b0;
   endtask

   // Hold off until every write has been answered and the mapper is idle.
   task automatic wait_drained();
      while (pending_writes.size() > 0 || offering || expected_maps.size() > 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Mostly bank select / bank data pairs and outer loads, some noise.
   task automatic queue_random_writes(int count);
      int queued;
      int pick;
      queued = 0;
      while (queued < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            pending_writes.push_back(cpu_write({3'b100, 12'($urandom), 1'b0},
                                               8'($urandom), 1'($urandom)));
            pending_writes.push_back(cpu_write({3'b100, 12'($urandom), 1'b1},
                                               8'($urandom), 1'($urandom)));
            queued += 2;
         end else begin
            if (pick < 55)
               pending_writes.push_back(cpu_write({WRAM_WINDOW, 13'($urandom)},
                                                  8'($urandom), 1'b1));
            else if (pick < 70)
               pending_writes.push_back(cpu_write({3'b100, 12'($urandom), 1'b1},
                                                  8'($urandom), 1'($urandom)));
            else if (pick < 80)
               pending_writes.push_back(cpu_write({3'b100, 12'($urandom), 1'b0},
                                                  8'($urandom), 1'($urandom)));
            else
               pending_writes.push_back(cpu_write(16'($urandom), 8'($urandom),
                                                  1'($urandom)));
            queued++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: decode edges, ignored writes, inversions, GNROM mode
      pending_writes.push_back(cpu_write(16'h0000, 8'h00, 1'b0));
      pending_writes.push_back(cpu_write(16'h5FFF, 8'hFF, 1'b1));
      pending_writes.push_back(cpu_write(16'h6000, 8'hFF, 1'b0));
      pending_writes.push_back(cpu_write(16'h7FFF, 8'h06, 1'b1));
      pending_writes.push_back(cpu_write(16'h8001, 8'hFF, 1'b0));
      pending_writes.push_back(cpu_write(16'h8000, 8'h06, 1'b0));
      pending_writes.push_back(cpu_write(16'h9FFF, 8'hA5, 1'b0));
      pending_writes.push_back(cpu_write(16'h9FFE, 8'h47, 1'b1));
      pending_writes.push_back(cpu_write(16'h8001, 8'h3C, 1'b0));
      pending_writes.push_back(cpu_write(16'h6000, 8'h00, 1'b1));
      pending_writes.push_back(cpu_write(16'h8000, 8'hC0, 1'b0));
      pending_writes.push_back(cpu_write(16'h8001, 8'h81, 1'b0));
      pending_writes.push_back(cpu_write(16'h8000, 8'hB9, 1'b0));
      pending_writes.push_back(cpu_write(16'h8001, 8'h7E, 1'b0));
      pending_writes.push_back(cpu_write(16'hA000, 8'h55, 1'b1));
      pending_writes.push_back(cpu_write(16'hA001, 8'hFF, 1'b0));
      pending_writes.push_back(cpu_write(16'hC000, 8'h12, 1'b0));
      pending_writes.push_back(cpu_write(16'hE001, 8'h34, 1'b0));
      pending_writes.push_back(cpu_write(16'hFFFF, 8'hFF, 1'b1));
      pending_writes.push_back(cpu_write(16'h7123, 8'h0B, 1'b1));
      pending_writes.push_back(cpu_write(16'h8000, 8'h02, 1'b0));
      pending_writes.push_back(cpu_write(16'h8001, 8'hF0, 1'b0));
      pending_writes.push_back(cpu_write(16'h6ABC, 8'hFF, 1'b1));
      pending_writes.push_back(cpu_write(16'h8000, 8'h45, 1'b0));
      pending_writes.push_back(cpu_write(16'h8001, 8'h00, 1'b0));
      wait_drained();

      // masks cleared, back-to-back traffic with no idling
      write_mask(CSR_PRG_BANK_MASK, 9'h000);
      write_mask(CSR_CHR_BANK_MASK, 9'h000);
      no_idle = 1'b1;
      queue_random_writes(300);
      wait_drained();
      no_idle = 1'b0;

      // full masks, unused indexes, and one long receiver stall
      write_mask(CSR_PRG_BANK_MASK, 9'h1FF);
      write_mask(CSR_CHR_BANK_MASK, 9'h1FF);
      write_mask(8'd2, 9'h055);
      write_mask(8'hFF, 9'h000);
      queue_random_writes(400);
      long_stall_asks++;
      wait_drained();

      write_mask(CSR_PRG_BANK_MASK, 9'h00F);
      write_mask(CSR_CHR_BANK_MASK, 9'h07F);
      queue_random_writes(300);
      wait_drained();

      repeat (3) begin
         write_mask(CSR_PRG_BANK_MASK, 9'($urandom_range(0, 511)));
         write_mask(CSR_CHR_BANK_MASK, 9'($urandom_range(0, 511)));
         queue_random_writes(300);
         wait_drained();
      end

      repeat (5) @(posedge clock);
      if (error_count == 0 && expected_maps.size() == 0)
         $display("tb_multicart_mmc3_bank_mapper: done, clean");
      else
         $display("tb_multicart_mmc3_bank_mapper: done, errors");
      $finish;
   end

endmodule

FILE: multicart_mmc3_bank_mapper.f
sv/mmc3bm_pkg.sv
sv/mmc3bm_regs.sv
sv/mmc3bm_banks.sv
sv/multicart_mmc3_bank_mapper.sv
bench/tb_multicart_mmc3_bank_mapper.sv
